// ----- src/abc_pkg.sv -----
// abc_pkg: shared types, constants and rotate helpers for the arx block cipher
// used by abc_keyregs, abc_round and arx_block_cipher_128_256_unit
`timescale 1ns / 1ps
`default_nettype none

package abc_pkg;

  localparam int ABC_ROUNDS  = 34;
  localparam int WORD_W      = 64;
  localparam int BLOCK_W     = 2 * WORD_W;
  localparam int CFG_IDX_W   = 2;
  localparam int ROT_R       = 8;
  localparam int ROT_L       = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_idx_t;

  // key words as held in the configuration registers
  typedef struct packed {
    word_t k3;
    word_t k2;
    word_t k1;
    word_t k0;
  } abc_key_t;

  // everything one pipeline stage carries: block words plus key schedule state
  typedef struct packed {
    word_t l2;
    word_t l1;
    word_t l0;
    word_t rk;
    word_t hi;
    word_t lo;
  } abc_st_t;

  function automatic word_t ror8(input word_t v);
    ror8 = {v[ROT_R-1:0], v[WORD_W-1:ROT_R]};
  endfunction

  function automatic word_t rol3(input word_t v);
    rol3 = {v[WORD_W-ROT_L-1:0], v[WORD_W-1:WORD_W-ROT_L]};
  endfunction

endpackage

`default_nettype wire

// ----- src/abc_keyregs.sv -----
// abc_keyregs: the four 64-bit key registers behind the plain write port
// depends on abc_pkg
`timescale 1ns / 1ps
`default_nettype none

module abc_keyregs
  import abc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [WORD_W-1:0]    cfg_wdata,
  output abc_key_t                  key
);

  abc_key_t key_r;
  abc_key_t key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_KEY0: key_nxt.k0 = cfg_wdata;
        CFG_KEY1: key_nxt.k1 = cfg_wdata;
        CFG_KEY2: key_nxt.k2 = cfg_wdata;
        CFG_KEY3: key_nxt.k3 = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

`default_nettype wire

// ----- src/abc_round.sv -----
// abc_round: one registered cipher round with its key schedule step
// depends on abc_pkg
`timescale 1ns / 1ps
`default_nettype none

module abc_round
  import abc_pkg::*;
#(
  parameter int RND = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    vld_i,
  input  wire abc_st_t st_i,
  output logic         vld_o,
  output abc_st_t      st_o
);

  logic    vld_r;
  abc_st_t st_r;
  abc_st_t st_nxt;
  word_t   hi_new;
  word_t   l_new;

  always_comb begin
    hi_new    = st_i.rk ^ (st_i.lo + ror8(st_i.hi));
    l_new     = (ror8(st_i.l0) + st_i.rk) ^ WORD_W'(RND);
    st_nxt.hi = hi_new;
    st_nxt.lo = hi_new ^ rol3(st_i.lo);
    st_nxt.rk = rol3(st_i.rk) ^ l_new;
    // queue turns so the word in use is always at the head
    st_nxt.l0 = st_i.l1;
    st_nxt.l1 = st_i.l2;
    st_nxt.l2 = l_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;

endmodule

`default_nettype wire

// ----- src/arx_block_cipher_128_256_unit.sv -----
// arx_block_cipher_128_256_unit: 128-bit block, 256-bit key arx cipher, one round per stage
// depends on abc_pkg, abc_keyregs, abc_round
//
//   port group   dir   width  contents
//   in_*         in    128    plain_lo [63:0], plain_hi [127:64]
//   out_*        out   128    cipher_lo [63:0], cipher_hi [127:64]
//   cfg_*        in    2/64   key word index, key word
//
// one beat per cycle while the pipe is not held; one pipeline register per round
// the key schedule travels with each block, so a key write counts from the next beat
// the whole pipe holds while the last stage has a beat that is not taken
// rst_n is synchronous; it clears the stage valid bits and the key words
`timescale 1ns / 1ps
`default_nettype none

module arx_block_cipher_128_256_unit
  import abc_pkg::*;
#(
  parameter int ROUNDS = ABC_ROUNDS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BLOCK_W-1:0]   in_tdata,   // plain_lo, plain_hi
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [BLOCK_W-1:0]        out_tdata,  // cipher_lo, cipher_hi
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [WORD_W-1:0]    cfg_wdata
);

  abc_key_t key;
  abc_st_t  st  [ROUNDS+1];
  logic     vld [ROUNDS+1];
  logic     adv;

  abc_keyregs u_keyregs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .key       (key)
  );

  assign adv = !vld[ROUNDS] || out_tready;

  assign vld[0]   = in_tvalid;
  assign st[0].lo = in_tdata[WORD_W-1:0];
  assign st[0].hi = in_tdata[BLOCK_W-1:WORD_W];
  assign st[0].rk = key.k0;
  assign st[0].l0 = key.k1;
  assign st[0].l1 = key.k2;
  assign st[0].l2 = key.k3;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    abc_round #(
      .RND (g)
    ) u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (vld[g]),
      .st_i  (st[g]),
      .vld_o (vld[g+1]),
      .st_o  (st[g+1])
    );
  end

  assign in_tready  = adv;
  assign out_tvalid = vld[ROUNDS];
  assign out_tdata  = {st[ROUNDS].hi, st[ROUNDS].lo};

endmodule

`default_nettype wire

// ----- tb/arx_block_cipher_128_256_unit_tb.sv -----
`timescale 1ns / 1ps
// arx_block_cipher_128_256_unit_tb: streams directed and random 128-bit blocks through the
// cipher under changing keys and checks every output beat against a block encryption model
// depends on abc_pkg and arx_block_cipher_128_256_unit

module arx_block_cipher_128_256_unit_tb;
  import abc_pkg::*;

  localparam int NUM_DIRECTED   = 16;
  localparam int NUM_SEGMENTS   = 8;
  localparam int SEGMENT_BLOCKS = 180;
  localparam int IDLE_PCT       = 71;
  localparam int BOTH_PCT       = 38;
  localparam int MAX_REPORTS    = 20;

  localparam word_t ONES = {WORD_W{1'b1}};

  localparam abc_key_t KEY_ZERO  = '0;
  localparam abc_key_t KEY_ONES  = '1;
  localparam abc_key_t KEY_MIX   = {64'h0, ONES, 64'h0, ONES};
  localparam abc_key_t KEY_ALT   = {2{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555}};
  localparam abc_key_t KEY_BYTES = {64'h1f1e_1d1c_1b1a_1918, 64'h1716_1514_1312_1110,
                                    64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100};

  typedef struct packed {
    abc_key_t key;
    word_t    lo;
    word_t    hi;
  } vec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [BLOCK_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [BLOCK_W-1:0] out_tdata;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_idx = CFG_KEY0;
  word_t              cfg_wdata = '0;

  abc_key_t           held_key = KEY_ZERO;
  logic [BLOCK_W-1:0] cipher_q [$];
  logic [BLOCK_W-1:0] want_blk;
  vec_t               directed_rows [NUM_DIRECTED];
  bit                 src_idle_on = 1'b0;
  bit                 sink_stall_on = 1'b0;
  int                 idle_pct = IDLE_PCT;
  int                 error_count = 0;
  int                 blocks_sent = 0;
  int                 blocks_checked = 0;
  int                 key_loads = 0;

  arx_block_cipher_128_256_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // plain_lo, plain_hi
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // cipher_lo, cipher_hi
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not finish, %0d blocks still outstanding", $time, cipher_q.size());
    $display("** arx_block_cipher_128_256_unit: FAILED **");
    $finish;
  end

  function automatic word_t rot_right8(input word_t v);
    return (v >> 8) | (v << (WORD_W - 8));
  endfunction

  function automatic word_t rot_left3(input word_t v);
    return (v << 3) | (v >> (WORD_W - 3));
  endfunction

  // full key schedule and all rounds for one block; result is {hi, lo}
  function automatic logic [BLOCK_W-1:0] encrypt_block(input abc_key_t key, input word_t pl,
                                                       input word_t ph);
    word_t lo;
    word_t hi;
    word_t rk;
    word_t nl;
    word_t sched [3];
    int    slot;
    lo = pl;
    hi = ph;
    rk = key.k0;
    sched[0] = key.k1;
    sched[1] = key.k2;
    sched[2] = key.k3;
    slot = 0;
    for (int r = 0; r < ABC_ROUNDS; r++) begin
      hi = rk ^ (lo + rot_right8(hi));
      lo = hi ^ rot_left3(lo);
      nl = (rot_right8(sched[slot]) + rk) ^ word_t'(r);
      rk = rot_left3(rk) ^ nl;
      sched[slot] = nl;
      slot = (slot == 2) ? 0 : slot + 1;
    end
    return {hi, lo};
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0: w = '0;
      1: w = ONES;
      2: w = word_t'(1) << $urandom_range(WORD_W - 1);
      3: w = ~(word_t'(1) << $urandom_range(WORD_W - 1));
      4: w = word_t'($urandom_range(255));
      default: ;
    endcase
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_block(input word_t lo, input word_t hi);
    while (src_idle_on && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cipher_q.push_back(encrypt_block(held_key, lo, hi));
    blocks_sent++;
    @(negedge clk);
  endtask

  // drain the pipe, then write the selected key words
  task automatic load_key(input abc_key_t key, input logic [3:0] mask);
    cfg_idx_t idx;
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
    idx = idx.first();
    repeat (4) begin
      if (mask[idx]) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= key[WORD_W*idx +: WORD_W];
        held_key[WORD_W*idx +: WORD_W] = key[WORD_W*idx +: WORD_W];
        @(negedge clk);
      end
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    key_loads++;
  endtask

  always @(negedge clk)
    out_tready <= sink_stall_on ? ($urandom_range(99) >= idle_pct) : 1'b1;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected beat, actual %h", $time, out_tdata);
      end else begin
        want_blk = cipher_q.pop_front();
        blocks_checked++;
        if (out_tdata[WORD_W-1:0] !== want_blk[WORD_W-1:0]) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: cipher_lo mismatch, expected %h actual %h", $time,
                     want_blk[WORD_W-1:0], out_tdata[WORD_W-1:0]);
        end
        if (out_tdata[BLOCK_W-1:WORD_W] !== want_blk[BLOCK_W-1:WORD_W]) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: cipher_hi mismatch, expected %h actual %h", $time,
                     want_blk[BLOCK_W-1:WORD_W], out_tdata[BLOCK_W-1:WORD_W]);
        end
      end
    end
  end

  initial begin
    abc_key_t seg_key;
    directed_rows = '{
      // reset key
      {KEY_ZERO,  64'h0, 64'h0},
      {KEY_ZERO,  ONES, ONES},
      {KEY_ZERO,  64'h1, 64'h0},
      {KEY_ZERO,  64'h0, 64'h8000_0000_0000_0000},
      {KEY_ZERO,  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
      // extreme and patterned keys
      {KEY_ONES,  64'h0, 64'h0},
      {KEY_ONES,  ONES, ONES},
      {KEY_ONES,  64'h8000_0000_0000_0000, 64'h1},
      {KEY_MIX,   64'h0, ONES},
      {KEY_MIX,   ONES, 64'h0},
      {KEY_BYTES, 64'h202e_7265_6e6f_6f70, 64'h6573_6f68_7420_6e49},
      {KEY_BYTES, 64'h0, 64'h0},
      {KEY_ALT,   64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210},
      {KEY_ALT,   64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff},
      // back to an all-zero key
      {KEY_ZERO,  64'h0, 64'h0},
      {KEY_ZERO,  64'hdead_beef_dead_beef, 64'hdead_beef_dead_beef}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].key != held_key)
        load_key(directed_rows[i].key, 4'hf);
      send_block(directed_rows[i].lo, directed_rows[i].hi);
    end

    // idle mixes: none, sender gaps, receiver stalls, both
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      seg_key = {rand_word(), rand_word(), rand_word(), rand_word()};
      if (seg == 0)
        load_key(KEY_ONES, 4'hf);
      else
        load_key(seg_key, (seg == 1) ? 4'hf : 4'($urandom_range(1, 15)));
      idle_pct = (seg % 4 == 3) ? BOTH_PCT : IDLE_PCT;
      src_idle_on = (seg % 4 == 1) || (seg % 4 == 3);
      sink_stall_on <= (seg % 4 == 2) || (seg % 4 == 3);
      repeat (SEGMENT_BLOCKS) send_block(rand_word(), rand_word());
    end

    in_tvalid <= 1'b0;
    src_idle_on = 1'b0;
    sink_stall_on <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (ABC_ROUNDS + 8) @(negedge clk);

    $display("%0d blocks sent, %0d checked, %0d key loads", blocks_sent, blocks_checked,
             key_loads);
    $display("covered reset, extreme, patterned and random keys under gap and stall mixes");
    if (error_count == 0) begin
      $display("** arx_block_cipher_128_256_unit: PASSED **");
    end else begin
      $display("%0d mismatches", error_count);
      $display("** arx_block_cipher_128_256_unit: FAILED **");
    end
    $finish;
  end

endmodule
